// File: hdl/urb_pkg.sv
// ----------------------------------------------------------------------------
// urb_pkg
// Shared types and constants for the uart register block: beat payloads,
// access modes, register offsets and interrupt identity codes.
// ----------------------------------------------------------------------------
package urb_pkg;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_level;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } rsp_t;

  // access modes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_RX    = 2'd2;

  // register offsets
  localparam logic [7:0] OFF_DATA   = 8'h00;
  localparam logic [7:0] OFF_IER    = 8'h01;
  localparam logic [7:0] OFF_IIR    = 8'h02;
  localparam logic [7:0] OFF_LCR    = 8'h03;
  localparam logic [7:0] OFF_MCR    = 8'h04;
  localparam logic [7:0] OFF_LSR    = 8'h05;
  localparam logic [7:0] OFF_MSR    = 8'h06;
  localparam logic [7:0] OFF_SCR    = 8'h07;
  localparam logic [7:0] OFF_MDR    = 8'h08;
  localparam logic [7:0] OFF_SUPCTL = 8'h10;
  localparam logic [7:0] OFF_SUPSTS = 8'h11;

  localparam logic [7:0] BANK_EXT   = 8'hBF;
  localparam logic [7:0] MODEM_STAT = 8'hB0;

  // interrupt identity codes
  localparam logic [7:0] ID_NONE = 8'h01;
  localparam logic [7:0] ID_LINE = 8'h06;
  localparam logic [7:0] ID_DATA = 8'h04;
  localparam logic [7:0] ID_TXE  = 8'h02;

  // line status bits
  localparam logic [7:0] LS_DR  = 8'h01;
  localparam logic [7:0] LS_OE  = 8'h02;
  localparam logic [7:0] LS_TXE = 8'h60;

endpackage

// File: hdl/urb_ram.sv
// ----------------------------------------------------------------------------
// urb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module urb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/uart_register_block_with_rx_fifo_core.sv
// ----------------------------------------------------------------------------
// uart_register_block_with_rx_fifo_core
// 16550-style register file with banked registers, interrupt identity
// priority and a receive ring fifo held in a ram.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while the result side is not stalled, every access or
// received byte is one pass; a beat taken into the input register moves to the
// result register when it advances; the fifo ram is read ahead every cycle at
// the next read pointer, with write forwarding, so a pop does not wait on the ram read
// reset: synchronous; the register file, valid flags and fifo pointers clear at
// once, input and result data and the fifo ram are not cleared, the ram needs no sweep
module uart_register_block_with_rx_fifo_core #(
  parameter int RX_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  urb_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output urb_pkg::rsp_t rsp
);

  localparam int PTR_W  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int FILL_W = $clog2(RX_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(RX_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(RX_DEPTH);

  // input register
  logic          s1_valid;
  urb_pkg::req_t s1;
  logic          advance;

  // architectural state
  logic [3:0]        int_enable;
  logic [7:0]        int_ident;
  logic [7:0]        fifo_ctrl;
  logic [7:0]        line_ctrl;
  logic [7:0]        modem_ctrl;
  logic [7:0]        line_status;
  logic [7:0]        scratch_pad;
  logic [7:0]        divisor_low;
  logic [7:0]        divisor_high;
  logic [7:0]        mode_def;
  logic [7:0]        enhanced_feat;
  logic [7:0]        xon_words  [2];
  logic [7:0]        xoff_words [2];
  logic [7:0]        supp_ctrl;
  logic [7:0]        supp_status;
  logic              tx_empty_pending;
  logic [1:0]        ident_read_count;
  logic [PTR_W-1:0]  rx_write_ptr;
  logic [PTR_W-1:0]  rx_read_ptr;
  logic [FILL_W-1:0] rx_fill;

  // next values
  logic [3:0]        int_enable_next;
  logic [7:0]        int_ident_next;
  logic [7:0]        fifo_ctrl_next;
  logic [7:0]        line_ctrl_next;
  logic [7:0]        modem_ctrl_next;
  logic [7:0]        line_status_next;
  logic [7:0]        scratch_pad_next;
  logic [7:0]        divisor_low_next;
  logic [7:0]        divisor_high_next;
  logic [7:0]        mode_def_next;
  logic [7:0]        enhanced_feat_next;
  logic [7:0]        xon_words_next  [2];
  logic [7:0]        xoff_words_next [2];
  logic [7:0]        supp_ctrl_next;
  logic [7:0]        supp_status_next;
  logic              tx_empty_pending_next;
  logic [1:0]        ident_read_count_next;
  logic [PTR_W-1:0]  rx_write_ptr_next;
  logic [PTR_W-1:0]  rx_read_ptr_next;
  logic [FILL_W-1:0] rx_fill_next;
  urb_pkg::rsp_t     rsp_next;

  // fifo ram and read-ahead forwarding
  logic             ram_we;
  logic [PTR_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;
  logic             fwd_hit;
  logic [7:0]       fwd_data;
  logic [7:0]       rx_head;

  function automatic logic [7:0] pick_ident(input logic [3:0] ie, input logic [7:0] ls,
                                            input logic txe_pend);
    logic [7:0] id;
    if (ie[2] && ((ls & urb_pkg::LS_OE) != 8'h00)) begin
      id = urb_pkg::ID_LINE;
    end else if (ie[0] && ((ls & urb_pkg::LS_DR) != 8'h00)) begin
      id = urb_pkg::ID_DATA;
    end else if (ie[1] && txe_pend) begin
      id = urb_pkg::ID_TXE;
    end else begin
      id = urb_pkg::ID_NONE;
    end
    return id;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // handshake
  assign advance   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1 <= req;
    end
  end

  assign rx_head = fwd_hit ? fwd_data : ram_rdata;

  always_comb begin
    logic       ext;
    logic       dlab;
    logic [2:0] cnt_inc;
    logic [7:0] wd;

    int_enable_next       = int_enable;
    int_ident_next        = int_ident;
    fifo_ctrl_next        = fifo_ctrl;
    line_ctrl_next        = line_ctrl;
    modem_ctrl_next       = modem_ctrl;
    line_status_next      = line_status;
    scratch_pad_next      = scratch_pad;
    divisor_low_next      = divisor_low;
    divisor_high_next     = divisor_high;
    mode_def_next         = mode_def;
    enhanced_feat_next    = enhanced_feat;
    xon_words_next        = xon_words;
    xoff_words_next       = xoff_words;
    supp_ctrl_next        = supp_ctrl;
    supp_status_next      = supp_status;
    tx_empty_pending_next = tx_empty_pending;
    ident_read_count_next = ident_read_count;
    rx_write_ptr_next     = rx_write_ptr;
    rx_read_ptr_next      = rx_read_ptr;
    rx_fill_next          = rx_fill;
    rsp_next              = '0;
    ram_we                = 1'b0;

    ext     = (line_ctrl == urb_pkg::BANK_EXT);
    dlab    = line_ctrl[7];
    cnt_inc = {1'b0, ident_read_count} + 3'd1;
    wd      = s1.write_data;

    case (s1.mode)
      urb_pkg::MODE_READ: begin
        case (s1.reg_offset)
          urb_pkg::OFF_DATA: begin
            if (dlab) begin
              rsp_next.read_data = divisor_low;
            end else begin
              if (rx_fill != '0) begin
                rsp_next.read_data = rx_head;
                rx_read_ptr_next   = ptr_inc(rx_read_ptr);
                rx_fill_next       = rx_fill - FILL_W'(1);
              end
              if (rx_fill_next != '0) begin
                line_status_next = line_status_next | urb_pkg::LS_DR;
              end else begin
                line_status_next = line_status_next & ~urb_pkg::LS_DR;
              end
              int_ident_next = pick_ident(int_enable_next, line_status_next,
                                          tx_empty_pending_next);
            end
          end
          urb_pkg::OFF_IER: begin
            rsp_next.read_data = dlab ? divisor_high : {4'h0, int_enable};
          end
          urb_pkg::OFF_IIR: begin
            if (ext) begin
              rsp_next.read_data = enhanced_feat;
            end else begin
              rsp_next.read_data = int_ident;
              if ((int_ident & 8'h0F) == urb_pkg::ID_TXE) begin
                // the second identity read showing transmit-empty acknowledges it
                ident_read_count_next = cnt_inc[1:0];
                if (cnt_inc >= 3'd2) begin
                  tx_empty_pending_next = 1'b0;
                  ident_read_count_next = 2'd0;
                  int_ident_next = pick_ident(int_enable_next, line_status_next,
                                              tx_empty_pending_next);
                end
              end
            end
          end
          urb_pkg::OFF_LCR: rsp_next.read_data = line_ctrl;
          urb_pkg::OFF_MCR: rsp_next.read_data = ext ? xon_words[0] : modem_ctrl;
          urb_pkg::OFF_LSR: begin
            if (ext) begin
              rsp_next.read_data = xon_words[1];
            end else begin
              rsp_next.read_data = line_status;
              line_status_next   = line_status & ~urb_pkg::LS_OE;
              int_ident_next = pick_ident(int_enable_next, line_status_next,
                                          tx_empty_pending_next);
            end
          end
          urb_pkg::OFF_MSR:    rsp_next.read_data = ext ? xoff_words[0] : urb_pkg::MODEM_STAT;
          urb_pkg::OFF_SCR:    rsp_next.read_data = ext ? xoff_words[1] : scratch_pad;
          urb_pkg::OFF_MDR:    rsp_next.read_data = mode_def;
          urb_pkg::OFF_SUPCTL: rsp_next.read_data = supp_ctrl;
          urb_pkg::OFF_SUPSTS: rsp_next.read_data = supp_status & 8'hFE;
          default: ;
        endcase
      end
      urb_pkg::MODE_WRITE: begin
        case (s1.reg_offset)
          urb_pkg::OFF_DATA: begin
            if (dlab) begin
              divisor_low_next = wd;
            end else begin
              line_status_next      = line_status | urb_pkg::LS_TXE;
              tx_empty_pending_next = 1'b1;
              ident_read_count_next = 2'd0;
              int_ident_next = pick_ident(int_enable_next, line_status_next,
                                          tx_empty_pending_next);
              rsp_next.tx_valid = 1'b1;
              rsp_next.tx_byte  = wd;
            end
          end
          urb_pkg::OFF_IER: begin
            if (dlab) begin
              divisor_high_next = wd;
            end else begin
              int_enable_next = wd[3:0];
              // rising transmit-empty enable while the transmitter is empty
              if (!int_enable[1] && wd[1] && line_status[5]) begin
                tx_empty_pending_next = 1'b1;
              end
              int_ident_next = pick_ident(int_enable_next, line_status_next,
                                          tx_empty_pending_next);
            end
          end
          urb_pkg::OFF_IIR: begin
            if (ext) begin
              enhanced_feat_next = wd;
            end else begin
              fifo_ctrl_next = wd;
              if (wd[1]) begin
                rx_write_ptr_next = '0;
                rx_read_ptr_next  = '0;
                rx_fill_next      = '0;
                line_status_next  = line_status_next & ~urb_pkg::LS_DR;
              end
              if (wd[2]) begin
                tx_empty_pending_next = 1'b0;
                line_status_next      = line_status_next | urb_pkg::LS_TXE;
              end
              int_ident_next = pick_ident(int_enable_next, line_status_next,
                                          tx_empty_pending_next);
            end
          end
          urb_pkg::OFF_LCR: line_ctrl_next = wd;
          urb_pkg::OFF_MCR: begin
            if (ext) begin
              xon_words_next[0] = wd;
            end else begin
              modem_ctrl_next = wd;
            end
          end
          urb_pkg::OFF_LSR: begin
            if (ext) begin
              xon_words_next[1] = wd;
            end
          end
          urb_pkg::OFF_MSR: begin
            if (ext) begin
              xoff_words_next[0] = wd;
            end
          end
          urb_pkg::OFF_SCR: begin
            if (ext) begin
              xoff_words_next[1] = wd;
            end else begin
              scratch_pad_next = wd;
            end
          end
          urb_pkg::OFF_MDR:    mode_def_next    = wd;
          urb_pkg::OFF_SUPCTL: supp_ctrl_next   = wd;
          urb_pkg::OFF_SUPSTS: supp_status_next = wd;
          default: ;
        endcase
      end
      urb_pkg::MODE_RX: begin
        if (rx_fill == FILL_MAX) begin
          line_status_next = line_status | urb_pkg::LS_OE;
        end else begin
          ram_we            = advance;
          rx_write_ptr_next = ptr_inc(rx_write_ptr);
          rx_fill_next      = rx_fill + FILL_W'(1);
        end
        if (rx_fill_next != '0) begin
          line_status_next = line_status_next | urb_pkg::LS_DR;
        end
        int_ident_next = pick_ident(int_enable_next, line_status_next,
                                    tx_empty_pending_next);
      end
      default: ;
    endcase

    rsp_next.irq_level = (int_ident_next != urb_pkg::ID_NONE);
  end

  // the ram always reads the entry that will be at the head next cycle
  assign ram_raddr = advance ? rx_read_ptr_next : rx_read_ptr;

  urb_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rx_write_ptr),
    .wdata (s1.rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= ram_we && (rx_write_ptr == ram_raddr);
    end
    fwd_data <= s1.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      int_enable       <= '0;
      int_ident        <= urb_pkg::ID_NONE;
      fifo_ctrl        <= '0;
      line_ctrl        <= '0;
      modem_ctrl       <= '0;
      line_status      <= urb_pkg::LS_TXE;
      scratch_pad      <= '0;
      divisor_low      <= '0;
      divisor_high     <= '0;
      mode_def         <= '0;
      enhanced_feat    <= '0;
      xon_words[0]     <= '0;
      xon_words[1]     <= '0;
      xoff_words[0]    <= '0;
      xoff_words[1]    <= '0;
      supp_ctrl        <= '0;
      supp_status      <= '0;
      tx_empty_pending <= 1'b0;
      ident_read_count <= '0;
      rx_write_ptr     <= '0;
      rx_read_ptr      <= '0;
      rx_fill          <= '0;
    end else if (advance) begin
      int_enable       <= int_enable_next;
      int_ident        <= int_ident_next;
      fifo_ctrl        <= fifo_ctrl_next;
      line_ctrl        <= line_ctrl_next;
      modem_ctrl       <= modem_ctrl_next;
      line_status      <= line_status_next;
      scratch_pad      <= scratch_pad_next;
      divisor_low      <= divisor_low_next;
      divisor_high     <= divisor_high_next;
      mode_def         <= mode_def_next;
      enhanced_feat    <= enhanced_feat_next;
      xon_words        <= xon_words_next;
      xoff_words       <= xoff_words_next;
      supp_ctrl        <= supp_ctrl_next;
      supp_status      <= supp_status_next;
      tx_empty_pending <= tx_empty_pending_next;
      ident_read_count <= ident_read_count_next;
      rx_write_ptr     <= rx_write_ptr_next;
      rx_read_ptr      <= rx_read_ptr_next;
      rx_fill          <= rx_fill_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  // fifo never holds more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rx_fill <= FILL_MAX)
    else $error("rx fill beyond depth");

  // empty or full fifo has both pointers at the same entry
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (rx_fill == '0 || rx_fill == FILL_MAX) |-> rx_write_ptr == rx_read_ptr)
    else $error("rx pointers out of step with fill");

  // data ready tracks fifo occupancy
  a_dr_fill: assert property (@(posedge clk) disable iff (rst)
    line_status[0] == (rx_fill != '0))
    else $error("data ready disagrees with fifo fill");

  // a held result carries the interrupt level of the current state
  a_irq_state: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.irq_level == (int_ident != urb_pkg::ID_NONE))
    else $error("irq level in result differs from identity");

  // input side only stalls with a beat waiting in the input register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && rsp_valid && rsp_stall)
    else $error("input stalled without a blocked beat");

endmodule

// File: test/uart_register_block_with_rx_fifo_core_tb.sv
// ----------------------------------------------------------------------------
// uart_register_block_with_rx_fifo_core_tb
// Drives register reads, register writes and received bytes into the uart
// register block with random idle on the request side and random stall on the result side. A mirror of
// the registers, banks, interrupt identity and receive fifo predicts each
// result beat, and every result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module uart_register_block_with_rx_fifo_core_tb;

  localparam int FIFO_DEPTH = 64;
  localparam logic [1:0] MODE_IDLE    = 2'd3;
  localparam logic [7:0] OFF_UNMAPPED = 8'hFF;

  class uart_reg_mirror;
    logic [3:0]    ier;
    logic [7:0]    iir, fcr, lcr, mcr, lsr, scr, dll, dlm, mdr, efr, supctl, supsts;
    logic [7:0]    xon [2];
    logic [7:0]    xoff [2];
    bit            txe_pend;
    int            iir_reads;
    logic [7:0]    rx_queue [$];
    urb_pkg::rsp_t expected_results [$];
    int            errors;

    function new();
      ier = '0;
      iir = urb_pkg::ID_NONE;
      fcr = '0;
      lcr = '0;
      mcr = '0;
      lsr = urb_pkg::LS_TXE;
      scr = '0;
      dll = '0;
      dlm = '0;
      mdr = '0;
      efr = '0;
      supctl = '0;
      supsts = '0;
      xon = '{8'h00, 8'h00};
      xoff = '{8'h00, 8'h00};
      txe_pend = 1'b0;
      iir_reads = 0;
      errors = 0;
    endfunction

    // priority: overrun, then data ready, then transmitter empty
    function void update_ident();
      if (ier[2] && (lsr & urb_pkg::LS_OE) != 8'h00)
        iir = urb_pkg::ID_LINE;
      else if (ier[0] && (lsr & urb_pkg::LS_DR) != 8'h00)
        iir = urb_pkg::ID_DATA;
      else if (ier[1] && txe_pend)
        iir = urb_pkg::ID_TXE;
      else
        iir = urb_pkg::ID_NONE;
    endfunction

    function logic [7:0] read_reg(input logic [7:0] off);
      logic [7:0] v;
      bit ext, dlab;
      v = 8'h00;
      ext = (lcr == urb_pkg::BANK_EXT);
      dlab = lcr[7];
      case (off)
        urb_pkg::OFF_DATA: begin
          if (dlab) begin
            v = dll;
          end else begin
            if (rx_queue.size() > 0) v = rx_queue.pop_front();
            if (rx_queue.size() > 0) lsr |= urb_pkg::LS_DR;
            else lsr &= ~urb_pkg::LS_DR;
            update_ident();
          end
        end
        urb_pkg::OFF_IER: v = dlab ? dlm : {4'h0, ier};
        urb_pkg::OFF_IIR: begin
          if (ext) begin
            v = efr;
          end else begin
            v = iir;
            // second identity read while transmit-empty is shown acknowledges it
            if ((iir & 8'h0F) == urb_pkg::ID_TXE) begin
              iir_reads++;
              if (iir_reads >= 2) begin
                txe_pend = 1'b0;
                iir_reads = 0;
                update_ident();
              end
            end
          end
        end
        urb_pkg::OFF_LCR: v = lcr;
        urb_pkg::OFF_MCR: v = ext ? xon[0] : mcr;
        urb_pkg::OFF_LSR: begin
          if (ext) begin
            v = xon[1];
          end else begin
            v = lsr;
            lsr &= ~urb_pkg::LS_OE;
            update_ident();
          end
        end
        urb_pkg::OFF_MSR: v = ext ? xoff[0] : urb_pkg::MODEM_STAT;
        urb_pkg::OFF_SCR: v = ext ? xoff[1] : scr;
        urb_pkg::OFF_MDR: v = mdr;
        urb_pkg::OFF_SUPCTL: v = supctl;
        urb_pkg::OFF_SUPSTS: v = {supsts[7:1], 1'b0};
        default: v = 8'h00;
      endcase
      return v;
    endfunction

    function bit write_reg(input logic [7:0] off, input logic [7:0] v);
      logic [3:0] old_ier;
      bit ext, dlab;
      ext = (lcr == urb_pkg::BANK_EXT);
      dlab = lcr[7];
      case (off)
        urb_pkg::OFF_DATA: begin
          if (dlab) begin
            dll = v;
            return 1'b0;
          end
          lsr |= urb_pkg::LS_TXE;
          txe_pend = 1'b1;
          iir_reads = 0;
          update_ident();
          return 1'b1;
        end
        urb_pkg::OFF_IER: begin
          if (dlab) begin
            dlm = v;
          end else begin
            old_ier = ier;
            ier = v[3:0];
            if (!old_ier[1] && ier[1] && lsr[5]) txe_pend = 1'b1;
            update_ident();
          end
        end
        urb_pkg::OFF_IIR: begin
          if (ext) begin
            efr = v;
          end else begin
            fcr = v;
            if (v[1]) begin
              rx_queue.delete();
              lsr &= ~urb_pkg::LS_DR;
            end
            if (v[2]) begin
              txe_pend = 1'b0;
              lsr |= urb_pkg::LS_TXE;
            end
            update_ident();
          end
        end
        urb_pkg::OFF_LCR: lcr = v;
        urb_pkg::OFF_MCR: if (ext) xon[0] = v; else mcr = v;
        urb_pkg::OFF_LSR: if (ext) xon[1] = v;
        urb_pkg::OFF_MSR: if (ext) xoff[0] = v;
        urb_pkg::OFF_SCR: if (ext) xoff[1] = v; else scr = v;
        urb_pkg::OFF_MDR: mdr = v;
        urb_pkg::OFF_SUPCTL: supctl = v;
        urb_pkg::OFF_SUPSTS: supsts = v;
        default: ;
      endcase
      return 1'b0;
    endfunction

    function void note_access(input urb_pkg::req_t r);
      urb_pkg::rsp_t e;
      e = '0;
      case (r.mode)
        urb_pkg::MODE_READ: e.read_data = read_reg(r.reg_offset);
        urb_pkg::MODE_WRITE: begin
          e.tx_valid = write_reg(r.reg_offset, r.write_data);
          if (e.tx_valid) e.tx_byte = r.write_data;
        end
        urb_pkg::MODE_RX: begin
          if (rx_queue.size() >= FIFO_DEPTH) lsr |= urb_pkg::LS_OE;
          else rx_queue.push_back(r.rx_byte);
          if (rx_queue.size() > 0) lsr |= urb_pkg::LS_DR;
          update_ident();
        end
        default: ;
      endcase
      e.irq_level = (iir != urb_pkg::ID_NONE);
      expected_results.push_back(e);
    endfunction

    function void check_result(input urb_pkg::rsp_t got);
      urb_pkg::rsp_t e;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result beat with nothing expected: rd %h irq %b txv %b txb %h",
                   $realtime, got.read_data, got.irq_level, got.tx_valid, got.tx_byte);
        return;
      end
      e = expected_results.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp/got: rd %h/%h irq %b/%b txv %b/%b txb %h/%h",
                   $realtime, e.read_data, got.read_data, e.irq_level, got.irq_level,
                   e.tx_valid, got.tx_valid, e.tx_byte, got.tx_byte);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  urb_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  urb_pkg::rsp_t rsp;

  uart_reg_mirror mirror = new();
  bit no_idle = 1'b0;
  int beats_sent = 0;

  logic [7:0] mapped_offs [11] = '{urb_pkg::OFF_DATA, urb_pkg::OFF_IER, urb_pkg::OFF_IIR,
                                   urb_pkg::OFF_LCR, urb_pkg::OFF_MCR, urb_pkg::OFF_LSR,
                                   urb_pkg::OFF_MSR, urb_pkg::OFF_SCR, urb_pkg::OFF_MDR,
                                   urb_pkg::OFF_SUPCTL, urb_pkg::OFF_SUPSTS};

  uart_register_block_with_rx_fifo_core #(.RX_DEPTH(FIFO_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #2 clk = ~clk;

  // results are checked before the new beat is noted, so a stray result is caught
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) mirror.check_result(rsp);
      if (req_valid && !req_stall) mirror.note_access(req);
    end
  end

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_lcr();
    case ($urandom_range(0, 5))
      0, 1, 2: return {1'b0, 7'($urandom)};
      3: return {1'b1, 7'($urandom)};
      4: return urb_pkg::BANK_EXT;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic issue(input logic [1:0] m, input logic [7:0] off,
                       input logic [7:0] wd, input logic [7:0] rb);
    urb_pkg::req_t r;
    int gap;
    r.mode = m;
    r.reg_offset = off;
    r.write_data = wd;
    r.rx_byte = rb;
    gap = idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    beats_sent++;
  endtask

  task automatic reg_rd(input logic [7:0] off);
    issue(urb_pkg::MODE_READ, off, 8'($urandom), 8'($urandom));
  endtask

  task automatic reg_wr(input logic [7:0] off, input logic [7:0] v);
    issue(urb_pkg::MODE_WRITE, off, v, 8'($urandom));
  endtask

  task automatic rx_in(input logic [7:0] b);
    issue(urb_pkg::MODE_RX, 8'($urandom), 8'($urandom), b);
  endtask

  // result side back-pressure
  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = idle_len();
      if (n == 0) begin
        rsp_stall <= 1'b0;
        @(posedge clk);
      end else begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    int kind, n, i;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset values, empty pop, transmit-empty enable and acknowledge
    reg_rd(urb_pkg::OFF_IIR);
    reg_rd(urb_pkg::OFF_LSR);
    reg_rd(urb_pkg::OFF_MSR);
    reg_rd(urb_pkg::OFF_DATA);
    reg_wr(urb_pkg::OFF_IER, 8'hFF);
    reg_rd(urb_pkg::OFF_IIR);
    reg_rd(urb_pkg::OFF_IIR);
    reg_wr(urb_pkg::OFF_DATA, 8'hA5);
    rx_in(8'h00);
    rx_in(8'hFF);
    reg_rd(urb_pkg::OFF_DATA);
    reg_wr(urb_pkg::OFF_IIR, 8'h06);
    reg_rd(urb_pkg::OFF_DATA);
    // divisor latch bank, then extended bank
    reg_wr(urb_pkg::OFF_LCR, 8'h80);
    reg_wr(urb_pkg::OFF_DATA, 8'hFF);
    reg_rd(urb_pkg::OFF_IER);
    reg_wr(urb_pkg::OFF_LCR, urb_pkg::BANK_EXT);
    reg_wr(urb_pkg::OFF_IIR, 8'h3C);
    reg_wr(urb_pkg::OFF_SCR, 8'hFF);
    reg_rd(urb_pkg::OFF_IIR);
    reg_wr(urb_pkg::OFF_LCR, 8'h00);
    reg_rd(OFF_UNMAPPED);
    reg_wr(urb_pkg::OFF_SUPSTS, 8'hFF);
    reg_rd(urb_pkg::OFF_SUPSTS);
    issue(MODE_IDLE, 8'hFF, 8'hFF, 8'hFF);

    while (beats_sent < 550) begin
      no_idle = ($urandom_range(0, 7) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        // long bursts run the fifo into overrun
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 6);
        for (i = 0; i < n; i++) rx_in(8'($urandom));
        if ($urandom_range(0, 2) == 0) reg_rd(urb_pkg::OFF_LSR);
      end else if (kind < 35) begin
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) reg_rd(urb_pkg::OFF_DATA);
        if ($urandom_range(0, 2) == 0) reg_rd(urb_pkg::OFF_LSR);
      end else if (kind < 45) begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) reg_rd(urb_pkg::OFF_IIR);
      end else if (kind < 55) begin
        if ($urandom_range(0, 1) == 0) reg_wr(urb_pkg::OFF_IER, 8'h00);
        reg_wr(urb_pkg::OFF_IER, 8'($urandom));
      end else if (kind < 62) begin
        reg_wr(urb_pkg::OFF_IIR, 8'($urandom));
      end else if (kind < 70) begin
        reg_wr(urb_pkg::OFF_DATA, 8'($urandom));
      end else if (kind < 85) begin
        i = $urandom_range(0, 10);
        if (mapped_offs[i] == urb_pkg::OFF_LCR)
          reg_wr(urb_pkg::OFF_LCR, pick_lcr());
        else if ($urandom_range(0, 1) == 0)
          reg_rd(mapped_offs[i]);
        else
          reg_wr(mapped_offs[i], 8'($urandom));
      end else if (kind < 92) begin
        reg_wr(urb_pkg::OFF_LCR, pick_lcr());
      end else begin
        issue(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    no_idle = 1'b0;
    req_valid <= 1'b0;
    // step past the last accept edge so its prediction is already queued
    do @(posedge clk); while (mirror.expected_results.size() != 0);
    repeat (10) @(posedge clk);
    if (mirror.errors == 0)
      $display("** uart_register_block_with_rx_fifo_core: PASSED **");
    else
      $display("** uart_register_block_with_rx_fifo_core: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("** uart_register_block_with_rx_fifo_core: FAILED **");
    $finish;
  end

endmodule
